// ----- hdl/rfsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsa_pkg
// Shared types and constants for the ring frame slot allocator: request and
// response transactions, controller commands, state encoding and field codes.
// ----------------------------------------------------------------------------
package rfsa_pkg;

   // slot ring geometry
   localparam int MAX_SLOTS = 64;
   localparam int SLOT_W    = 6;
   localparam int CNT_W     = 7;
   localparam int DIM_W     = 12;
   localparam int PROD_W    = 2 * DIM_W;

   // record layout: header followed by pixels
   localparam int HDR_BYTES = 32;
   localparam int PIX_BYTES = 2;
   localparam int REC_W     = 28;
   localparam int POS_W     = 33;
   localparam int END_W     = 34;

   // slot number meaning "no slot"
   localparam logic [CNT_W-1:0] NO_SLOT = '1;

   // operation codes
   localparam logic [1:0] OP_RESERVE = 2'd0;
   localparam logic [1:0] OP_COMMIT  = 2'd1;
   localparam logic [1:0] OP_LOOKUP  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_PREV_UNK   = 2'd1;
   localparam logic [1:0] STATUS_NOT_FILLED = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_MAX_SLOTS   = 2'd0;
   localparam logic [1:0] CSR_MEM_SIZE    = 2'd1;
   localparam logic [1:0] CSR_BASE_OFFSET = 2'd2;

   // configuration reset values
   localparam logic [CNT_W-1:0] MAX_SLOTS_RST = 7'd64;
   localparam logic [31:0]      MEM_SIZE_RST  = 32'd1048576;
   localparam logic [31:0]      BASE_OFF_RST  = 32'd0;

   typedef struct packed {
      logic [1:0]       operation;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       record_offset;
      logic [DIM_W-1:0]  out_width;
      logic [DIM_W-1:0]  out_height;
      logic [CNT_W-1:0]  filled_slots;
      logic signed [31:0] total_frames;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic mult;
      logic sum;
      logic finish;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_SUM,
      ST_FINISH
   } fsm_state_type;

endpackage

// ----- hdl/rfsa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsa_ctrl
// Sequencer for one transaction: capture and memory read, multiply, offset
// sum, then decision, state update and response.
// ----------------------------------------------------------------------------
module rfsa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output rfsa_pkg::cmd_type cmd
);
   import rfsa_pkg::*;

   fsm_state_type state_ff;
   fsm_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // a captured transaction always goes on to the multiply step
   a_capture_to_mult: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_MULT)
      else $error("capture not followed by multiply");

   // finishing frees the sequencer for the next transaction
   a_finish_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy)
      else $error("busy after finish");

endmodule

// ----- hdl/rfsa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsa_datapath
// Configuration registers, slot bookkeeping, slot offset and dimension
// memories, record size arithmetic and the response register.
// ----------------------------------------------------------------------------
module rfsa_datapath (
   input  logic              clock,
   input  logic              reset,
   input  rfsa_pkg::cmd_type cmd,
   input  rfsa_pkg::req_type req_data,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output logic              rsp_valid,
   output rfsa_pkg::rsp_type rsp_data
);
   import rfsa_pkg::*;

   // configuration
   logic [CNT_W-1:0] max_slots_ff;
   logic [31:0]      mem_size_ff;
   logic [31:0]      base_offset_ff;

   // bookkeeping
   logic [CNT_W-1:0] last_slot_ff,    last_slot_in;
   logic [CNT_W-1:0] pending_slot_ff, pending_slot_in;
   logic [CNT_W-1:0] filled_count_ff, filled_count_in;
   logic [31:0]      frame_total_ff,  frame_total_in;

   // slot memories
   logic [31:0]       slot_offsets_ff [MAX_SLOTS];
   logic [PROD_W-1:0] slot_dims_ff    [MAX_SLOTS];
   logic [SLOT_W-1:0] rd_addr;
   logic [31:0]       rd_off_ff;
   logic [PROD_W-1:0] rd_dim_ff;
   logic              off_we;
   logic              dim_we;
   logic [SLOT_W-1:0] wr_slot;
   logic [31:0]       wr_off;
   logic [PROD_W-1:0] wr_dim;

   // arithmetic pipeline
   req_type           req_ff;
   logic [PROD_W-1:0] new_prod_ff;
   logic [PROD_W-1:0] prev_prod_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [REC_W-1:0]  rec_new_ff;
   logic [REC_W-1:0]  rec_prev;
   logic [31:0]       prev_off;
   logic [CNT_W-1:0]  next_slot;
   logic [CNT_W-1:0]  limit;
   logic [END_W-1:0]  end_sum;
   logic              wrap;

   // response
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_slots_ff   <= MAX_SLOTS_RST;
         mem_size_ff    <= MEM_SIZE_RST;
         base_offset_ff <= BASE_OFF_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_SLOTS:   max_slots_ff   <= csr_wdata[CNT_W-1:0];
            CSR_MEM_SIZE:    mem_size_ff    <= csr_wdata;
            CSR_BASE_OFFSET: base_offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // memory read address: previous slot, pending slot or looked-up slot
   always_comb begin
      case (req_data.operation)
         OP_RESERVE: rd_addr = last_slot_ff[SLOT_W-1:0];
         OP_COMMIT:  rd_addr = pending_slot_ff[SLOT_W-1:0];
         default:    rd_addr = req_data.slot_index;
      endcase
   end

   // slot memories, registered read at capture, write at finish
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_off_ff <= slot_offsets_ff[rd_addr];
         rd_dim_ff <= slot_dims_ff[rd_addr];
      end
      if (off_we) begin
         slot_offsets_ff[wr_slot] <= wr_off;
      end
      if (dim_we) begin
         slot_dims_ff[wr_slot] <= wr_dim;
      end
   end

   // transaction capture and dimension products
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.mult) begin
         new_prod_ff  <= PROD_W'(req_ff.width) * PROD_W'(req_ff.height);
         prev_prod_ff <= PROD_W'(rd_dim_ff[DIM_W-1:0]) * PROD_W'(rd_dim_ff[PROD_W-1:DIM_W]);
      end
   end

   // record sizes and the position after the previous record
   assign next_slot = last_slot_ff + CNT_W'(1);
   assign prev_off  = (last_slot_ff == '0) ? base_offset_ff : rd_off_ff;
   assign rec_prev  = REC_W'(HDR_BYTES) + REC_W'(prev_prod_ff) * REC_W'(PIX_BYTES);

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         if (last_slot_ff == NO_SLOT) begin
            pos_ff <= POS_W'(base_offset_ff);
         end else begin
            pos_ff <= POS_W'(prev_off) + POS_W'(rec_prev);
         end
         rec_new_ff <= REC_W'(HDR_BYTES) + REC_W'(new_prod_ff) * REC_W'(PIX_BYTES);
      end
   end

   // end of the new record against the region size
   assign end_sum = END_W'(pos_ff) + END_W'(rec_new_ff);
   assign wrap    = (end_sum >= END_W'(mem_size_ff));
   assign limit   = (max_slots_ff > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : max_slots_ff;

   // decision, bookkeeping update and response
   always_comb begin
      last_slot_in    = last_slot_ff;
      pending_slot_in = pending_slot_ff;
      filled_count_in = filled_count_ff;
      frame_total_in  = frame_total_ff;
      off_we          = 1'b0;
      dim_we          = 1'b0;
      wr_slot         = '0;
      wr_off          = pos_ff[31:0];
      wr_dim          = {req_ff.height, req_ff.width};
      rsp_in          = '0;
      case (req_ff.operation)
         OP_RESERVE: begin
            if (next_slot < limit && next_slot > filled_count_ff) begin
               rsp_in.status = STATUS_PREV_UNK;
               rsp_in.slot   = next_slot[SLOT_W-1:0];
            end else begin
               if (next_slot < limit && !wrap) begin
                  wr_slot              = next_slot[SLOT_W-1:0];
                  off_we               = cmd.finish;
                  rsp_in.record_offset = pos_ff[31:0];
               end else begin
                  wr_slot              = '0;
                  rsp_in.record_offset = base_offset_ff;
               end
               dim_we            = cmd.finish;
               pending_slot_in   = {1'b0, wr_slot};
               rsp_in.status     = STATUS_OK;
               rsp_in.slot       = wr_slot;
               rsp_in.out_width  = req_ff.width;
               rsp_in.out_height = req_ff.height;
            end
         end
         OP_COMMIT: begin
            last_slot_in   = pending_slot_ff;
            frame_total_in = frame_total_ff + 32'd1;
            if (pending_slot_ff != NO_SLOT) begin
               if (filled_count_ff <= pending_slot_ff) begin
                  filled_count_in = filled_count_ff + CNT_W'(1);
               end
               rsp_in.slot          = pending_slot_ff[SLOT_W-1:0];
               rsp_in.record_offset = (pending_slot_ff == '0) ? base_offset_ff : rd_off_ff;
               rsp_in.out_width     = rd_dim_ff[DIM_W-1:0];
               rsp_in.out_height    = rd_dim_ff[PROD_W-1:DIM_W];
            end
         end
         OP_LOOKUP: begin
            rsp_in.slot = req_ff.slot_index;
            if (CNT_W'(req_ff.slot_index) < filled_count_ff) begin
               rsp_in.record_offset = (req_ff.slot_index == '0) ? base_offset_ff : rd_off_ff;
               rsp_in.out_width     = rd_dim_ff[DIM_W-1:0];
               rsp_in.out_height    = rd_dim_ff[PROD_W-1:DIM_W];
            end else begin
               rsp_in.status = STATUS_NOT_FILLED;
            end
         end
         default: ;
      endcase
      rsp_in.filled_slots = filled_count_in;
      rsp_in.total_frames = signed'(frame_total_in);
   end

   // bookkeeping registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_slot_ff    <= NO_SLOT;
         pending_slot_ff <= NO_SLOT;
         filled_count_ff <= '0;
         frame_total_ff  <= '1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (cmd.finish) begin
            last_slot_ff    <= last_slot_in;
            pending_slot_ff <= pending_slot_in;
            filled_count_ff <= filled_count_in;
            frame_total_ff  <= frame_total_in;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a response strobe only follows a finish step
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.finish))
      else $error("response without finish");

   // fill count never passes the slot count
   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_count_ff <= CNT_W'(MAX_SLOTS))
      else $error("fill count out of range");

   // fill count moves only on a finished commit
   a_filled_on_commit: assert property (@(posedge clock) disable iff (reset)
      !$stable(filled_count_ff) |-> $past(cmd.finish && req_ff.operation == OP_COMMIT))
      else $error("fill count changed outside commit");

endmodule

// ----- hdl/ring_frame_slot_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_frame_slot_allocator
// The rsp_valid strobe is registered from the finish step of the sequence.
// A new transaction starts only once busy is low, after the memory read,
//   multiply, offset add and end compare sequence on the slot memories.
// Reset clears the slot bookkeeping and loads the configuration defaults;
//   slot memories are not cleared. The receiver cannot stall responses.
// ----------------------------------------------------------------------------
module ring_frame_slot_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rfsa_pkg::req_type req_data,
   output logic              rsp_valid,
   output rfsa_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import rfsa_pkg::*;

   cmd_type cmd;

   // sequencer
   rfsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // bookkeeping, memories and arithmetic
   rfsa_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule
